@@ src/wsrm_pkg.sv @@
package wsrm_pkg;

    localparam int PATTERN_MAX_DEF = 32;

    localparam logic [7:0] SYM_ANY  = 8'h2E;
    localparam logic [7:0] SYM_STAR = 8'h2A;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_START  = 2'd2,
        CMD_TEXT   = 2'd3
    } cmd_t;

    // handed from one cell to the cell on its right
    typedef struct packed {
        logic       tok;
        logic       bit_new;
        logic       bit_old;
        logic       bit_prev;
        logic [7:0] sym;
        logic       sym_ok;
    } link_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic       kill;
        logic       row_clr;
        logic       snap;
        logic       start_mode;
        logic [7:0] text;
        logic [7:0] ld_sym;
    } ctrl_t;

    function automatic logic elem_hits(input logic [7:0] elem, input logic [7:0] c);
        return (elem == SYM_ANY) || (elem == c);
    endfunction

endpackage

@@ src/wsrm_cell.sv @@
module wsrm_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  wsrm_pkg::ctrl_t   ctrl,
    input  logic              load,
    input  wsrm_pkg::link_t   link_in,
    output wsrm_pkg::link_t   link_out
);

    logic       bit_reg, bit_next;
    logic       tok_reg, tok_next;
    logic       old_reg, old_next;
    logic [7:0] sym_reg, sym_next;

    logic       is_star;
    logic       hit_own;
    logic       hit_prev;
    logic       upd;

    always_comb begin
        is_star  = (sym_reg == wsrm_pkg::SYM_STAR);
        hit_own  = wsrm_pkg::elem_hits(sym_reg, ctrl.text);
        hit_prev = link_in.sym_ok && wsrm_pkg::elem_hits(link_in.sym, ctrl.text);

        if (ctrl.start_mode) begin
            upd = is_star && link_in.bit_prev;
        end else if (is_star) begin
            upd = link_in.bit_prev || (hit_prev && bit_reg);
        end else begin
            upd = link_in.bit_old && hit_own;
        end

        priority if (ctrl.row_clr) begin
            bit_next = 1'b0;
        end else if (link_in.tok) begin
            bit_next = upd;
        end else begin
            bit_next = bit_reg;
        end

        tok_next = ctrl.kill ? 1'b0 : link_in.tok;
        old_next = ctrl.snap ? bit_reg : old_reg;
        sym_next = load ? ctrl.ld_sym : sym_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
            tok_reg <= 1'b0;
        end else begin
            bit_reg <= bit_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        old_reg <= old_next;
        sym_reg <= sym_next;
    end

    always_comb begin
        link_out.tok      = tok_reg;
        link_out.bit_new  = bit_reg;
        link_out.bit_old  = old_reg;
        link_out.bit_prev = link_in.bit_new;
        link_out.sym      = sym_reg;
        link_out.sym_ok   = 1'b1;
    end

endmodule

@@ src/wildcard_star_regex_match.sv @@
// clear and append items give no result
// a start or text item sweeps the cell row one column per cycle: its result is registered
// once the sweep reaches the last column and any earlier result is taken; the next item
// can be taken while that result is valid, but no text byte is taken during a sweep
// reset: pattern length zero, match row holds only the empty-prefix bit,
// pattern bytes stay undefined until appended
module wildcard_star_regex_match #(
    parameter int PATTERN_MAX = wsrm_pkg::PATTERN_MAX_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_symbol,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_matched
);

    localparam int LW = $clog2(PATTERN_MAX + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [LW-1:0]   len_reg, len_next;
    logic [LW-1:0]   cnt_reg, cnt_next;
    logic            r0_reg, r0_next;
    logic            r0_old_reg, r0_old_next;
    logic            launch_reg, launch_next;
    logic            m_valid_reg, m_valid_next;
    logic            m_matched_reg, m_matched_next;
    logic [7:0]      text_reg, text_next;
    logic            mode_reg, mode_next;

    wsrm_pkg::cmd_t  cmd;
    logic            accept;
    logic            run;
    logic            edit;
    logic            done;

    wsrm_pkg::ctrl_t ctrl;
    wsrm_pkg::link_t link [0:PATTERN_MAX];
    logic [PATTERN_MAX:0] row_bits;
    logic [PATTERN_MAX:1] tok_vec;
    logic [PATTERN_MAX:1] load_vec;

    assign cmd    = wsrm_pkg::cmd_t'(s_cmd);
    assign s_ready = (state_reg == ST_IDLE);
    assign accept = s_valid && s_ready;
    assign run    = accept && ((cmd == wsrm_pkg::CMD_START) || (cmd == wsrm_pkg::CMD_TEXT));
    assign edit   = accept && ((cmd == wsrm_pkg::CMD_CLEAR) || (cmd == wsrm_pkg::CMD_APPEND));
    assign done   = (state_reg == ST_BUSY) && (cnt_reg == len_reg) && (!m_valid_reg || m_ready);

    always_comb begin
        ctrl.kill       = accept;
        ctrl.row_clr    = edit;
        ctrl.snap       = run;
        ctrl.start_mode = mode_reg;
        ctrl.text       = text_reg;
        ctrl.ld_sym     = s_symbol;
    end

    // column zero of the row
    always_comb begin
        link[0].tok      = launch_reg;
        link[0].bit_new  = r0_reg;
        link[0].bit_old  = r0_old_reg;
        link[0].bit_prev = r0_reg;
        link[0].sym      = 8'h00;
        link[0].sym_ok   = 1'b0;
    end

    assign row_bits[0] = r0_reg;

    for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
        assign load_vec[j] = accept && (cmd == wsrm_pkg::CMD_APPEND) && (len_reg == LW'(j - 1));
        assign row_bits[j] = link[j].bit_new;
        assign tok_vec[j]  = link[j].tok;

        wsrm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .load     (load_vec[j]),
            .link_in  (link[j-1]),
            .link_out (link[j])
        );
    end

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        r0_next        = r0_reg;
        r0_old_next    = r0_old_reg;
        launch_next    = run;
        m_valid_next   = m_valid_reg && !m_ready;
        m_matched_next = m_matched_reg;
        text_next      = run ? s_symbol : text_reg;
        mode_next      = run ? (cmd == wsrm_pkg::CMD_START) : mode_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (edit) begin
                    r0_next = 1'b1;
                    if (cmd == wsrm_pkg::CMD_CLEAR) begin
                        len_next = '0;
                    end else if (len_reg != LW'(PATTERN_MAX)) begin
                        len_next = len_reg + LW'(1);
                    end
                end else if (run) begin
                    r0_old_next = r0_reg;
                    r0_next     = (cmd == wsrm_pkg::CMD_START);
                    cnt_next    = '0;
                    state_next  = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (cnt_reg != len_reg) begin
                    cnt_next = cnt_reg + LW'(1);
                end else if (done) begin
                    m_valid_next   = 1'b1;
                    m_matched_next = row_bits[len_reg];
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            cnt_reg     <= '0;
            r0_reg      <= 1'b1;
            r0_old_reg  <= 1'b1;
            launch_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            r0_reg      <= r0_next;
            r0_old_reg  <= r0_old_next;
            launch_reg  <= launch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_matched_reg <= m_matched_next;
        text_reg      <= text_next;
        mode_reg      <= mode_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

    // at most one sweep moves along the row
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({tok_vec, launch_reg}))
        else $error("more than one token in the cell row");

    a_run_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        run |=> (state_reg == ST_BUSY) && (cnt_reg == '0) && launch_reg)
        else $error("sweep not started after a start or text item");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BUSY) |-> (cnt_reg <= len_reg))
        else $error("column count beyond pattern length");

    a_edit_row: assert property (@(posedge aclk) disable iff (!aresetn)
        edit |=> r0_reg && (row_bits[PATTERN_MAX:1] == '0))
        else $error("match row not reset after a pattern change");

    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> m_valid && (state_reg == ST_IDLE))
        else $error("finished sweep gave no result");

endmodule
